FILE: hw/rtl/byte_stuffed_frame_receiver_unit_assert.svh
// Assertion macros shared by the frame receiver modules.
// Every macro samples on clk_i and is switched off while rst_ni is low.
`ifndef BYTE_STUFFED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define BSFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BSFR_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define BSFR_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BSFR_ASSERT(lbl, prop, msg)
`define BSFR_IMPLY(lbl, ante, cons, msg)
`define BSFR_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/bsfr_pkg.sv
package bsfr_pkg;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_OK       = 3'd1,
    KIND_MISMATCH = 3'd2,
    KIND_SHORT    = 3'd3,
    KIND_ABORTED  = 3'd4
  } kind_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START  = 2'd0;
  localparam logic [1:0] CFG_END    = 2'd1;
  localparam logic [1:0] CFG_ESCAPE = 2'd2;

  localparam logic [7:0] START_RESET  = 8'd126;
  localparam logic [7:0] END_RESET    = 8'd127;
  localparam logic [7:0] ESCAPE_RESET = 8'd125;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // All results caused by one received byte. A second result, when there
  // is one, is always a payload byte.
  typedef struct packed {
    logic       two;
    kind_e      kind;
    logic [7:0] d0;
    logic [7:0] d1;
  } rec_t;

endpackage

FILE: hw/rtl/bsfr_front.sv
`include "byte_stuffed_frame_receiver_unit_assert.svh"

module bsfr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              rx_valid_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              q_full_i,
  output logic              rx_ready_o,
  output logic              push_o,
  output bsfr_pkg::rec_t    rec_o
);

  typedef struct packed {
    logic [7:0]  h0;
    logic [7:0]  h1;
    logic [1:0]  cnt;
    logic [15:0] sum;
    logic        emit;
    logic [7:0]  ebyte;
  } hold_t;

  logic [7:0]  start_q, end_q, esc_q;
  logic        in_frame_q, in_frame_d;
  logic        esc_pend_q, esc_pend_d;
  logic [7:0]  h0_q, h1_q;
  logic [1:0]  cnt_q;
  logic [15:0] sum_q;
  hold_t       cur, s1, s2, nxt;
  logic        accept;
  logic        two_steps;
  logic        any_res;

  // One decoded byte into the two-byte hold; the oldest byte leaves as
  // payload once the hold is full.
  function automatic hold_t dec_step(hold_t h, logic [7:0] d);
    hold_t r;
    r       = h;
    r.emit  = 1'b0;
    r.ebyte = 8'd0;
    if (h.cnt == 2'd0) begin
      r.h0  = d;
      r.cnt = 2'd1;
    end else if (h.cnt == 2'd1) begin
      r.h1  = d;
      r.cnt = 2'd2;
    end else begin
      r.emit  = 1'b1;
      r.ebyte = h.h0;
      r.sum   = h.sum + {8'd0, h.h0};
      r.h0    = h.h1;
      r.h1    = d;
    end
    return r;
  endfunction

  assign rx_ready_o = !q_full_i;
  assign accept     = rx_valid_i && rx_ready_o;

  always_comb begin
    cur       = '{h0: h0_q, h1: h1_q, cnt: cnt_q, sum: sum_q, emit: 1'b0, ebyte: 8'd0};
    s1        = dec_step(cur, esc_q);
    s2        = dec_step(s1, rx_byte_i);
    nxt       = cur;
    two_steps = 1'b0;
    any_res   = 1'b0;
    rec_o     = '{two: 1'b0, kind: bsfr_pkg::KIND_PAYLOAD, d0: 8'd0, d1: 8'd0};
    in_frame_d = in_frame_q;
    esc_pend_d = esc_pend_q;

    if (!in_frame_q) begin
      if (rx_byte_i == start_q) begin
        in_frame_d = 1'b1;
        esc_pend_d = 1'b0;
        nxt        = '0;
      end
    end else if (esc_pend_q) begin
      esc_pend_d = 1'b0;
      if (rx_byte_i == start_q || rx_byte_i == end_q || rx_byte_i == esc_q) begin
        nxt = dec_step(cur, rx_byte_i);
      end else begin
        two_steps = 1'b1;
        nxt       = s2;
      end
    end else if (rx_byte_i == end_q) begin
      any_res = 1'b1;
      if (cnt_q != 2'd2) begin
        rec_o.kind = bsfr_pkg::KIND_SHORT;
      end else if ({h0_q, h1_q} == sum_q) begin
        rec_o.kind = bsfr_pkg::KIND_OK;
      end else begin
        rec_o.kind = bsfr_pkg::KIND_MISMATCH;
      end
      in_frame_d = 1'b0;
      esc_pend_d = 1'b0;
      nxt        = '0;
    end else if (rx_byte_i == start_q) begin
      // Start inside a frame: report the abort and reopen straight away.
      any_res    = 1'b1;
      rec_o.kind = bsfr_pkg::KIND_ABORTED;
      esc_pend_d = 1'b0;
      nxt        = '0;
    end else if (rx_byte_i == esc_q) begin
      esc_pend_d = 1'b1;
    end else begin
      nxt = dec_step(cur, rx_byte_i);
    end

    // Collect payload bytes pushed out of the hold.
    if (two_steps) begin
      if (s1.emit && s2.emit) begin
        any_res   = 1'b1;
        rec_o.two = 1'b1;
        rec_o.d0  = s1.ebyte;
        rec_o.d1  = s2.ebyte;
      end else if (s1.emit || s2.emit) begin
        any_res  = 1'b1;
        rec_o.d0 = s1.emit ? s1.ebyte : s2.ebyte;
      end
    end else if (nxt.emit) begin
      any_res  = 1'b1;
      rec_o.d0 = nxt.ebyte;
    end
  end

  assign push_o = accept && any_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= bsfr_pkg::START_RESET;
      end_q   <= bsfr_pkg::END_RESET;
      esc_q   <= bsfr_pkg::ESCAPE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bsfr_pkg::CFG_START:  start_q <= cfg_data_i;
        bsfr_pkg::CFG_END:    end_q   <= cfg_data_i;
        bsfr_pkg::CFG_ESCAPE: esc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_pend_q <= 1'b0;
      h0_q       <= 8'd0;
      h1_q       <= 8'd0;
      cnt_q      <= 2'd0;
      sum_q      <= 16'd0;
    end else if (accept) begin
      in_frame_q <= in_frame_d;
      esc_pend_q <= esc_pend_d;
      h0_q       <= nxt.h0;
      h1_q       <= nxt.h1;
      cnt_q      <= nxt.cnt;
      sum_q      <= nxt.sum;
    end
  end

  `BSFR_IMPLY(a_status_single, push_o && (rec_o.kind != bsfr_pkg::KIND_PAYLOAD), !rec_o.two, "status record carries a second result")
  `BSFR_IMPLY(a_hold_bound, 1'b1, cnt_q != 2'd3, "hold count beyond two")

endmodule

FILE: hw/rtl/bsfr_queue.sv
`include "byte_stuffed_frame_receiver_unit_assert.svh"

module bsfr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bsfr_pkg::rec_t wdata_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output bsfr_pkg::rec_t rdata_o
);

  bsfr_pkg::rec_t                   mem_q [bsfr_pkg::QDEPTH];
  logic [bsfr_pkg::QPTR_W-1:0]      wr_q, rd_q;
  logic [bsfr_pkg::QCNT_W-1:0]      cnt_q;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == bsfr_pkg::QCNT_W'(bsfr_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `BSFR_IMPLY(a_no_overflow, push_i, !full_o, "record pushed into a full queue")
  `BSFR_NEXT(a_ptr_gap, 1'b1, (bsfr_pkg::QPTR_W'(wr_q - rd_q)) == bsfr_pkg::QPTR_W'(cnt_q), "queue pointers disagree with fill count")

endmodule

FILE: hw/rtl/bsfr_back.sv
`include "byte_stuffed_frame_receiver_unit_assert.svh"

module bsfr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  bsfr_pkg::rec_t q_rec_i,
  output logic           q_pop_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic [2:0]     kind_o,
  output logic [7:0]     payload_o,
  output logic           last_o
);

  logic        valid_q, valid_d;
  logic [2:0]  kind_q, kind_d;
  logic [7:0]  pay_q, pay_d;
  logic        last_q, last_d;
  logic        phase_q, phase_d;
  logic        load;

  assign load = !valid_q || res_ready_i;

  always_comb begin
    valid_d = valid_q;
    kind_d  = kind_q;
    pay_d   = pay_q;
    last_d  = last_q;
    phase_d = phase_q;
    q_pop_o = 1'b0;
    if (load) begin
      valid_d = q_valid_i;
      if (q_valid_i) begin
        if (phase_q) begin
          // Second result of a record is always a payload byte.
          kind_d  = bsfr_pkg::KIND_PAYLOAD;
          pay_d   = q_rec_i.d1;
          last_d  = 1'b1;
          phase_d = 1'b0;
          q_pop_o = 1'b1;
        end else begin
          kind_d  = q_rec_i.kind;
          pay_d   = q_rec_i.d0;
          last_d  = !q_rec_i.two;
          phase_d = q_rec_i.two;
          q_pop_o = !q_rec_i.two;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    pay_q  <= pay_d;
    last_q <= last_d;
  end

  assign res_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign payload_o   = pay_q;
  assign last_o      = last_q;

  `BSFR_IMPLY(a_phase_holds_rec, phase_q, q_valid_i && valid_q && !last_q, "second half pending without its record")

endmodule

FILE: hw/rtl/byte_stuffed_frame_receiver_unit.sv
// Byte-stuffed frame receiver. Raw serial bytes enter on the rx channel, one
// per transfer, and the unit can take a new byte in every clock cycle while its
// queue is not full. Bytes are ignored until an unescaped start marker opens a
// frame; inside a frame an escape marker makes a following marker literal,
// while an escape followed by any other byte keeps both bytes. Decoded bytes
// pass through a two-byte hold, so the last two body bytes of a frame are
// never streamed: an unescaped end marker compares them, read big-endian, with
// the 16-bit wrapping sum of the payload bytes already sent and reports ok,
// mismatch or too short (fewer than two body bytes). A start marker inside a
// frame reports aborted and reopens the frame. Payload sent before a failing
// status is not recalled; the status tells the consumer to drop it. Each
// result transfer carries kind, payload (zero for status kinds) and last, which
// marks the final result caused by one input byte. A byte causes zero, one or
// two results; the result port moves one per cycle while the consumer is ready,
// and a four-record queue between the decoder and the output register absorbs
// bursts from bytes with two results. Results pass through the queue and then
// the output register. The marker registers are written through the cfg
// channel (index 0 start, 1 end, 2 escape, other indexes ignored), which is
// always ready, and should only be written while no results are outstanding.
module byte_stuffed_frame_receiver_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration writes.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // Received bytes.
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  // Results.
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] payload_o,
  output logic       last_o
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  bsfr_pkg::rec_t push_rec;
  bsfr_pkg::rec_t head_rec;

  // Register writes never stall.
  assign cfg_ready_o = 1'b1;

  // Front: marker detection, escape handling, hold and checksum state.
  bsfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rx_valid_i  (rx_valid_i),
    .rx_byte_i   (rx_byte_i),
    .q_full_i    (q_full),
    .rx_ready_o  (rx_ready_o),
    .push_o      (q_push),
    .rec_o       (push_rec)
  );

  // Queue of per-byte result records, so the front never waits on a
  // single stalled result.
  bsfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_rec),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rdata_o (head_rec)
  );

  // Back: splits each record into result transfers through the output
  // register.
  bsfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_rec_i     (head_rec),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .kind_o      (kind_o),
    .payload_o   (payload_o),
    .last_o      (last_o)
  );

endmodule
